@@ hw/rtl/gccpm_pkg.sv @@
// ----------------------------------------------------------------------------
// gccpm_pkg
// Shared types and constants of the character-class pattern matcher.
// ----------------------------------------------------------------------------
package gccpm_pkg;

	localparam int MAX_ELEMENTS       = 16;
	localparam int RANGES_PER_ELEMENT = 4;
	localparam int ELEM_W             = $clog2(MAX_ELEMENTS);
	localparam int SLOT_W             = $clog2(RANGES_PER_ELEMENT);
	localparam int CNT_W              = ELEM_W + 1;

	typedef enum logic [2:0] {
		OP_LOAD_RANGE = 3'd0,
		OP_LOAD_COUNT = 3'd1,
		OP_START      = 3'd2,
		OP_TEXT       = 3'd3,
		OP_END        = 3'd4
	} op_t;

	typedef struct packed {
		logic              we;
		logic [ELEM_W-1:0] elem;
		logic [SLOT_W-1:0] slot;
		logic              vld;
		logic [7:0]        lo;
		logic [7:0]        hi;
	} range_wr_t;

	typedef struct packed {
		logic [7:0] cmin;
		logic [7:0] cmax;
		logic       unb;
	} base_entry_t;

	typedef struct packed {
		logic [7:0] wmin;
		logic [7:0] wmax;
	} work_entry_t;

	function automatic work_entry_t take_one(work_entry_t w);
		work_entry_t r;
		r.wmin = (w.wmin != 8'd0) ? w.wmin - 8'd1 : 8'd0;
		r.wmax = (w.wmax != 8'd0) ? w.wmax - 8'd1 : 8'd0;
		return r;
	endfunction

endpackage

@@ hw/rtl/gccpm_class_mem.sv @@
// ----------------------------------------------------------------------------
// gccpm_class_mem
// Range table with two registered read ports and character-class test.
// ----------------------------------------------------------------------------
module gccpm_class_mem (
	input  logic                       clk,
	input  logic                       arst_n,
	input  gccpm_pkg::range_wr_t       wr,
	input  logic [gccpm_pkg::ELEM_W-1:0] ra_a,
	input  logic [gccpm_pkg::ELEM_W-1:0] ra_b,
	input  logic [7:0]                 ch,
	output logic                       acc_a,
	output logic                       acc_b
);

	localparam int NR = gccpm_pkg::RANGES_PER_ELEMENT;

	logic [15:0]   mem [gccpm_pkg::MAX_ELEMENTS][NR];
	logic [NR-1:0] vld_q [gccpm_pkg::MAX_ELEMENTS];
	logic [15:0]   rd_a_s1 [NR];
	logic [15:0]   rd_b_s1 [NR];
	logic [NR-1:0] vd_a_s1;
	logic [NR-1:0] vd_b_s1;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.elem][wr.slot] <= {wr.hi, wr.lo};
		end
		for (int s = 0; s < NR; s++) begin
			rd_a_s1[s] <= mem[ra_a][s];
			rd_b_s1[s] <= mem[ra_b][s];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < gccpm_pkg::MAX_ELEMENTS; e++) begin
				vld_q[e] <= '0;
			end
			vd_a_s1 <= '0;
			vd_b_s1 <= '0;
		end else begin
			if (wr.we) begin
				vld_q[wr.elem][wr.slot] <= wr.vld;
			end
			vd_a_s1 <= vld_q[ra_a];
			vd_b_s1 <= vld_q[ra_b];
		end
	end

	always_comb begin
		acc_a = 1'b0;
		acc_b = 1'b0;
		for (int s = 0; s < NR; s++) begin
			if (vd_a_s1[s] && ch >= rd_a_s1[s][7:0] && ch <= rd_a_s1[s][15:8]) begin
				acc_a = 1'b1;
			end
			if (vd_b_s1[s] && ch >= rd_b_s1[s][7:0] && ch <= rd_b_s1[s][15:8]) begin
				acc_b = 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/gccpm_count_mem.sv @@
// ----------------------------------------------------------------------------
// gccpm_count_mem
// Base and working repeat-count memories with registered reads.
// ----------------------------------------------------------------------------
module gccpm_count_mem (
	input  logic                         clk,
	input  logic                         base_we,
	input  logic [gccpm_pkg::ELEM_W-1:0] base_wa,
	input  gccpm_pkg::base_entry_t       base_wd,
	input  logic [gccpm_pkg::ELEM_W-1:0] base_ra,
	output gccpm_pkg::base_entry_t       base_rd,
	input  logic                         work_we,
	input  logic [gccpm_pkg::ELEM_W-1:0] work_wa,
	input  gccpm_pkg::work_entry_t       work_wd,
	input  logic [gccpm_pkg::ELEM_W-1:0] work_ra,
	output gccpm_pkg::work_entry_t       work_rd
);

	gccpm_pkg::base_entry_t base_mem [gccpm_pkg::MAX_ELEMENTS];
	gccpm_pkg::work_entry_t work_mem [gccpm_pkg::MAX_ELEMENTS];

	always_ff @(posedge clk) begin
		if (base_we) begin
			base_mem[base_wa] <= base_wd;
		end
		if (work_we) begin
			work_mem[work_wa] <= work_wd;
		end
		base_rd <= base_mem[base_ra];
		work_rd <= work_mem[work_ra];
	end

endmodule

@@ hw/rtl/greedy_char_class_pattern_matcher.sv @@
// ----------------------------------------------------------------------------
// greedy_char_class_pattern_matcher
// Anchored greedy matcher over a loaded table of character-class elements.
// ----------------------------------------------------------------------------
// Channel  Dir  Fields (low bit up)
// s_*      in   tuser: opcode[2:0]; tdata: element_index, range_slot,
//               range_enable, range_low, range_high, count_min, count_max,
//               repeat_unbounded, text_char
// m_*      out  tdata: matched, final_element, zero pad
// cfg_*    in   cfg_data: element_count
//
// A load leaves the matcher idle. A start sweeps the count memory, copying base
// counts into working counts. A character is ignored once the match has failed;
// moving on or past an element waits for a count-memory read. An end scans the
// working minimums unless the match has failed or the last element is satisfied.
// Reset clears range valid bits and control; count and range memories hold
// until written. A pending result does not block input; a second result waits
// for the output register.
// ----------------------------------------------------------------------------
module greedy_char_class_pattern_matcher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // element_index, range_slot, range_enable, range_low,
	                              // range_high, count_min, count_max, repeat_unbounded,
	                              // text_char
	input  logic [2:0]  s_tuser,  // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // matched, final_element, zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data  // element_count
);

	localparam int EW = gccpm_pkg::ELEM_W;
	localparam int CW = gccpm_pkg::CNT_W;

	typedef enum logic [2:0] {
		ST_IDLE, ST_COPY, ST_STEP, ST_TAKE, ST_END, ST_SCAN, ST_OUT
	} state_t;

	state_t          state_q;
	logic [EW-1:0]   cur_q;
	logic            failed_q;
	logic            chk_q;
	logic            ok_q;
	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   ecount_q;
	logic [7:0]      ch_q;
	logic            m_valid_q;
	logic            m_matched_q;
	logic [EW-1:0]   m_final_q;

	logic            in_xfer;
	logic            out_load;
	gccpm_pkg::op_t  op;
	logic [3:0]      in_elem;
	logic [1:0]      in_slot;

	gccpm_pkg::range_wr_t   rwr;
	gccpm_pkg::base_entry_t base_wd;
	gccpm_pkg::base_entry_t base_rd;
	gccpm_pkg::work_entry_t work_wd;
	gccpm_pkg::work_entry_t work_rd;
	logic            base_we;
	logic            work_we;
	logic [EW-1:0]   work_wa;
	logic [EW-1:0]   base_ra;
	logic [EW-1:0]   work_ra;
	logic [EW-1:0]   ra_a;
	logic [EW-1:0]   ra_b;
	logic [EW-1:0]   cur_p1;
	logic            acc_a;
	logic            acc_b;
	logic            has_next;
	logic            exh;
	logic [CW-1:0]   cfg_v;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_xfer   = s_tvalid && s_tready;
	assign out_load  = (state_q == ST_OUT) && (!m_valid_q || m_tready);
	assign op        = gccpm_pkg::op_t'(s_tuser);
	assign in_elem   = s_tdata[3:0];
	assign in_slot   = s_tdata[5:4];
	assign cur_p1    = cur_q + EW'(1);
	assign has_next  = ({1'b0, cur_q} + CW'(1)) < ecount_q;
	assign exh       = chk_q && work_rd.wmin == 8'd0 && !base_rd.unb && work_rd.wmax == 8'd0;

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'd0, m_final_q, m_matched_q};

	always_comb begin
		rwr.we   = in_xfer && op == gccpm_pkg::OP_LOAD_RANGE;
		rwr.elem = in_elem[EW-1:0];
		rwr.slot = in_slot[gccpm_pkg::SLOT_W-1:0];
		rwr.vld  = s_tdata[6];
		rwr.lo   = s_tdata[14:7];
		rwr.hi   = s_tdata[22:15];
		base_we      = in_xfer && op == gccpm_pkg::OP_LOAD_COUNT;
		base_wd.cmin = s_tdata[30:23];
		base_wd.cmax = s_tdata[38:31];
		base_wd.unb  = s_tdata[39];
	end

	always_comb begin
		base_ra = cur_q;
		work_ra = cur_q;
		ra_a    = cur_q;
		ra_b    = cur_p1;
		work_we = 1'b0;
		work_wa = cur_q;
		work_wd = gccpm_pkg::take_one(work_rd);
		case (state_q)
			ST_COPY: begin
				base_ra = cnt_q[EW-1:0];
				work_we = cnt_q != '0;
				work_wa = EW'(cnt_q - CW'(1));
				work_wd.wmin = base_rd.cmin;
				work_wd.wmax = base_rd.cmax;
			end
			ST_STEP: begin
				base_ra = cur_p1;
				work_ra = cur_p1;
				ra_a    = cur_p1;
				ra_b    = cur_p1 + EW'(1);
				work_we = !exh && !(work_rd.wmin == 8'd0 && has_next && acc_b) && acc_a;
			end
			ST_TAKE: begin
				work_we = 1'b1;
			end
			ST_SCAN: begin
				work_ra = cnt_q[EW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		cfg_v = cfg_data;
		if (cfg_v == '0) begin
			cfg_v = CW'(1);
		end else if (cfg_v > CW'(gccpm_pkg::MAX_ELEMENTS)) begin
			cfg_v = CW'(gccpm_pkg::MAX_ELEMENTS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_q       <= '0;
			failed_q    <= 1'b0;
			chk_q       <= 1'b0;
			ok_q        <= 1'b0;
			cnt_q       <= '0;
			ecount_q    <= CW'(1);
			ch_q        <= '0;
			m_valid_q   <= 1'b0;
			m_matched_q <= 1'b0;
			m_final_q   <= '0;
		end else begin
			if (cfg_valid) begin
				ecount_q <= cfg_v;
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						case (op)
							gccpm_pkg::OP_START: begin
								cnt_q   <= '0;
								state_q <= ST_COPY;
							end
							gccpm_pkg::OP_TEXT: begin
								ch_q  <= s_tdata[47:40];
								chk_q <= 1'b1;
								if (!failed_q) begin
									state_q <= ST_STEP;
								end
							end
							gccpm_pkg::OP_END: begin
								state_q <= ST_END;
							end
							default: begin
							end
						endcase
					end
				end
				ST_COPY: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(gccpm_pkg::MAX_ELEMENTS)) begin
						cur_q    <= '0;
						failed_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				ST_STEP: begin
					chk_q <= 1'b0;
					if (exh) begin
						if (has_next) begin
							cur_q <= cur_p1;
						end else begin
							failed_q <= 1'b1;
							state_q  <= ST_IDLE;
						end
					end else if (work_rd.wmin == 8'd0 && has_next && acc_b) begin
						cur_q   <= cur_p1;
						state_q <= ST_TAKE;
					end else begin
						failed_q <= !acc_a;
						state_q  <= ST_IDLE;
					end
				end
				ST_TAKE: begin
					state_q <= ST_IDLE;
				end
				ST_END: begin
					if (failed_q) begin
						ok_q    <= 1'b0;
						state_q <= ST_OUT;
					end else if (!has_next && (work_rd.wmin == 8'd0 || base_rd.unb)) begin
						ok_q    <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						ok_q    <= 1'b1;
						cnt_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q != '0 && work_rd.wmin != 8'd0) begin
						ok_q <= 1'b0;
					end
					if (cnt_q == ecount_q) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						m_matched_q <= ok_q;
						m_final_q   <= cur_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	gccpm_class_mem u_class (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (rwr),
		.ra_a   (ra_a),
		.ra_b   (ra_b),
		.ch     (ch_q),
		.acc_a  (acc_a),
		.acc_b  (acc_b)
	);

	gccpm_count_mem u_count (
		.clk     (clk),
		.base_we (base_we),
		.base_wa (in_elem[EW-1:0]),
		.base_wd (base_wd),
		.base_ra (base_ra),
		.base_rd (base_rd),
		.work_we (work_we),
		.work_wa (work_wa),
		.work_wd (work_wd),
		.work_ra (work_ra),
		.work_rd (work_rd)
	);

endmodule
